>>> hdl/tpp_pkg.sv
// ----------------------------------------------------------------------------
// tpp_pkg
// Shared types and constants of the trapezoid position profile block.
// ----------------------------------------------------------------------------
package tpp_pkg;

   localparam int SampleRateHzDefault = 1000;
   localparam int FracBitsDefault     = 32;

   // One request item
   typedef struct packed {
      logic               func;
      logic signed [31:0] goal_pos;
      logic signed [31:0] cur_pos;
      logic [19:0]        velocity_rpm;
      logic [19:0]        accel_rpm;
      logic [19:0]        decel_rpm;
      logic [23:0]        sample_index;
   } req_item_type;

   // One response item
   typedef struct packed {
      logic [30:0]        sample_count;
      logic signed [31:0] position;
      logic               accel_raised;
   } rsp_item_type;

   // Configuration register values
   typedef struct packed {
      logic [20:0]        ticks_per_turn;
      logic [19:0]        max_accel_rpm;
      logic [19:0]        max_velocity_rpm;
      logic signed [31:0] pos_upper;
      logic signed [31:0] pos_lower;
      logic [7:0]         accel_dist_gain;
   } cfg_type;

   // Register word index
   typedef enum logic [2:0] {
      REG_TICKS_PER_TURN   = 3'd0,
      REG_MAX_ACCEL_RPM    = 3'd1,
      REG_MAX_VELOCITY_RPM = 3'd2,
      REG_POS_UPPER        = 3'd3,
      REG_POS_LOWER        = 3'd4,
      REG_ACCEL_DIST_GAIN  = 3'd5
   } reg_index_type;

   // Item function codes
   localparam logic FUNC_PLAN   = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   // Multiply-divide unit request and response
   typedef struct packed {
      logic        start;
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] c;
   } md_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] q;
   } md_rsp_type;

   typedef enum logic [1:0] {
      MD_IDLE,
      MD_MUL,
      MD_CHK,
      MD_DIV
   } md_state_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_V,
      S_VMAX,
      S_A,
      S_D,
      S_AMAX,
      S_LIM,
      S_CLAMP,
      S_X1,
      S_X2,
      S_FIT,
      S_TA,
      S_TD,
      S_T1,
      S_TF,
      S_CNT,
      S_T,
      S_SEL,
      S_P,
      S_Q,
      S_CRU,
      S_POS,
      S_FIN
   } seq_state_type;

endpackage

>>> hdl/tpp_muldiv.sv
// ----------------------------------------------------------------------------
// tpp_muldiv
// Shared unit: floor(a*b/c) over the exact 128-bit product, saturated.
// Four 32x32 partial products, a range check, then one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tpp_muldiv (
   input  logic               clock,
   input  logic               reset,
   input  tpp_pkg::md_req_type md_req,
   output tpp_pkg::md_rsp_type md_rsp
);
   import tpp_pkg::*;

   md_state_type state_ff, state_in;
   logic [1:0]   k_ff, k_in;
   logic [5:0]   cnt_ff, cnt_in;
   logic         done_ff, done_in;
   logic [63:0]  a_ff, a_in, b_ff, b_in, c_ff, c_in;
   logic [127:0] acc_ff, acc_in;
   logic [63:0]  r_ff, r_in, lo_ff, lo_in;

   logic [31:0]  ma, mb;
   logic [63:0]  prod;
   logic [127:0] shifted;
   logic [63:0]  rs;
   logic         ge;

   // Partial product of the current quarter
   always_comb begin
      ma = k_ff[1] ? a_ff[63:32] : a_ff[31:0];
      mb = k_ff[0] ? b_ff[63:32] : b_ff[31:0];
      prod = ma * mb;
      case (k_ff)
         2'd0:    shifted = {64'd0, prod};
         2'd3:    shifted = {prod, 64'd0};
         default: shifted = {32'd0, prod, 32'd0};
      endcase
      rs = {r_ff[62:0], lo_ff[63]};
      ge = r_ff[63] || (rs >= c_ff);
   end

   // Sequence multiply, range check and restoring division
   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      a_in     = a_ff;
      b_in     = b_ff;
      c_in     = c_ff;
      acc_in   = acc_ff;
      r_in     = r_ff;
      lo_in    = lo_ff;
      case (state_ff)
         MD_IDLE: begin
            if (md_req.start) begin
               a_in     = md_req.a;
               b_in     = md_req.b;
               c_in     = md_req.c;
               acc_in   = '0;
               k_in     = 2'd0;
               state_in = MD_MUL;
            end
         end
         MD_MUL: begin
            acc_in = acc_ff + shifted;
            k_in   = k_ff + 2'd1;
            if (k_ff == 2'd3) begin
               state_in = MD_CHK;
            end
         end
         MD_CHK: begin
            if ((c_ff == 64'd0) || (acc_ff[127:64] >= c_ff)) begin
               lo_in    = '1;
               done_in  = 1'b1;
               state_in = MD_IDLE;
            end else begin
               r_in     = acc_ff[127:64];
               lo_in    = acc_ff[63:0];
               cnt_in   = 6'd0;
               state_in = MD_DIV;
            end
         end
         MD_DIV: begin
            // quotient bits shift into the low word as dividend bits leave
            r_in   = ge ? (rs - c_ff) : rs;
            lo_in  = {lo_ff[62:0], ge};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               done_in  = 1'b1;
               state_in = MD_IDLE;
            end
         end
         default: state_in = MD_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      k_ff   <= k_in;
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      c_ff   <= c_in;
      acc_ff <= acc_in;
      r_ff   <= r_in;
      lo_ff  <= lo_in;
   end

   assign md_rsp.done = done_ff;
   assign md_rsp.q    = lo_ff;

endmodule

>>> hdl/tpp_seq.sv
// ----------------------------------------------------------------------------
// tpp_seq
// Sequencer: holds the profile state and steps plan and sample items
// through the shared multiply-divide unit.
// ----------------------------------------------------------------------------
module tpp_seq #(
   parameter int SAMPLE_RATE_HZ = tpp_pkg::SampleRateHzDefault,
   parameter int FRAC_BITS      = tpp_pkg::FracBitsDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tpp_pkg::cfg_type      cfg,
   input  logic                 in_valid,
   input  tpp_pkg::req_item_type in_item,
   output logic                 busy,
   output logic                 out_valid,
   input  logic                 out_take,
   output tpp_pkg::rsp_item_type out_item,
   output tpp_pkg::md_req_type   md_req,
   input  tpp_pkg::md_rsp_type   md_rsp
);
   import tpp_pkg::*;

   localparam logic [63:0] QOne = 64'd1 << FRAC_BITS;
   localparam logic [63:0] Rate = 64'(SAMPLE_RATE_HZ);

   seq_state_type      state_ff, state_in;
   logic               wait_ff, wait_in;
   logic signed [31:0] qi_ff, qi_in, qf_ff, qf_in;
   logic [32:0]        dist_ff, dist_in;
   logic [19:0]        vel_ff, vel_in, acc_ff, acc_in, dec_ff, dec_in;
   logic [23:0]        idx_ff, idx_in;
   logic [63:0]        v_ff, v_in, a_ff, a_in, d_ff, d_in;
   logic [63:0]        amax_ff, amax_in, lim_ff, lim_in, x1_ff, x1_in;
   logic [63:0]        ta_ff, ta_in, td_ff, td_in, tf_ff, tf_in;
   logic [63:0]        tmp_ff, tmp_in, t_ff, t_in, w_ff, w_in;
   logic               dm_ff, dm_in;
   logic signed [31:0] start_ff, start_in, end_ff, end_in, last_ff, last_in;
   logic signed [31:0] pos_ff, pos_in;
   logic               raised_ff, raised_in;
   logic [30:0]        cnt_ff, cnt_in;

   logic               op_state, op_done;
   logic signed [31:0] qf_clamp;
   logic [32:0]        dist_new, sdist;
   logic               down;
   logic [63:0]        q, a_c, d_c, vn, ce, both, tf_s, r_v, n_v, cnt_r;
   logic [64:0]        sum65, tf65, both65;
   logic signed [33:0] newpos;

   function automatic logic [63:0] rnd(input logic [63:0] x);
      logic [64:0] s;
      s = ({1'b0, x} >> (FRAC_BITS - 1)) + 65'd1;
      return s[64:1];
   endfunction

   function automatic logic [63:0] umin(input logic [63:0] x, input logic [63:0] y);
      return (x < y) ? x : y;
   endfunction

   function automatic logic [63:0] umax(input logic [63:0] x, input logic [63:0] y);
      return (x > y) ? x : y;
   endfunction

   // Clamp target and measure distance at item entry
   always_comb begin
      if (in_item.goal_pos > cfg.pos_upper) begin
         qf_clamp = cfg.pos_upper;
      end else if (in_item.goal_pos < cfg.pos_lower) begin
         qf_clamp = cfg.pos_lower;
      end else begin
         qf_clamp = in_item.goal_pos;
      end
      if (qf_clamp >= in_item.cur_pos) begin
         dist_new = 33'({qf_clamp[31], qf_clamp} - {in_item.cur_pos[31],
                                                   in_item.cur_pos});
      end else begin
         dist_new = 33'({in_item.cur_pos[31], in_item.cur_pos}
                        - {qf_clamp[31], qf_clamp});
      end
   end

   // Shared unit operands per step
   always_comb begin
      op_state = 1'b1;
      md_req.a = '0;
      md_req.b = '0;
      md_req.c = '0;
      case (state_ff)
         S_V:    begin md_req.a = 64'(vel_ff); md_req.b = 64'(cfg.ticks_per_turn);
                       md_req.c = 64'd60; end
         S_VMAX: begin md_req.a = 64'(cfg.max_velocity_rpm);
                       md_req.b = 64'(cfg.ticks_per_turn); md_req.c = 64'd60; end
         S_A:    begin md_req.a = 64'(acc_ff); md_req.b = 64'(cfg.ticks_per_turn);
                       md_req.c = 64'd60; end
         S_D:    begin md_req.a = 64'(dec_ff); md_req.b = 64'(cfg.ticks_per_turn);
                       md_req.c = 64'd60; end
         S_AMAX: begin md_req.a = 64'(cfg.max_accel_rpm);
                       md_req.b = 64'(cfg.ticks_per_turn); md_req.c = 64'd60; end
         S_LIM:  begin md_req.a = 64'(cfg.accel_dist_gain); md_req.b = 64'(dist_ff);
                       md_req.c = 64'd1; end
         S_X1:   begin md_req.a = v_ff; md_req.b = v_ff; md_req.c = a_ff << 1; end
         S_X2:   begin md_req.a = v_ff; md_req.b = v_ff; md_req.c = d_ff << 1; end
         S_TA:   begin md_req.a = v_ff; md_req.b = QOne; md_req.c = a_ff; end
         S_TD:   begin md_req.a = v_ff; md_req.b = QOne; md_req.c = d_ff; end
         S_T1:   begin md_req.a = 64'(dist_ff); md_req.b = QOne; md_req.c = v_ff; end
         S_CNT:  begin md_req.a = tf_ff; md_req.b = Rate; md_req.c = 64'd1; end
         S_T:    begin md_req.a = 64'(idx_ff); md_req.b = QOne; md_req.c = Rate; end
         S_P:    begin md_req.a = w_ff; md_req.b = w_ff; md_req.c = QOne; end
         S_Q:    begin md_req.a = dm_ff ? d_ff : a_ff; md_req.b = tmp_ff;
                       md_req.c = 64'd2; end
         S_CRU:  begin md_req.a = v_ff; md_req.b = w_ff; md_req.c = 64'd1; end
         default: op_state = 1'b0;
      endcase
      md_req.start = op_state && !wait_ff;
      op_done      = op_state && wait_ff && md_rsp.done;
   end

   // Step control and state update
   always_comb begin
      state_in  = state_ff;
      wait_in   = wait_ff;
      qi_in     = qi_ff;     qf_in   = qf_ff;     dist_in = dist_ff;
      vel_in    = vel_ff;    acc_in  = acc_ff;    dec_in  = dec_ff;
      idx_in    = idx_ff;
      v_in      = v_ff;      a_in    = a_ff;      d_in    = d_ff;
      amax_in   = amax_ff;   lim_in  = lim_ff;    x1_in   = x1_ff;
      ta_in     = ta_ff;     td_in   = td_ff;     tf_in   = tf_ff;
      tmp_in    = tmp_ff;    t_in    = t_ff;      w_in    = w_ff;
      dm_in     = dm_ff;
      start_in  = start_ff;  end_in  = end_ff;    last_in = last_ff;
      pos_in    = pos_ff;    raised_in = raised_ff;
      cnt_in    = cnt_ff;
      q         = md_rsp.q;
      cnt_r     = rnd(q);

      a_c    = umin(umin(a_ff, lim_ff), amax_ff);
      d_c    = umin(umin(d_ff, lim_ff), amax_ff);
      sum65  = {1'b0, x1_ff} + {1'b0, tmp_ff};
      vn     = umin(v_ff, 64'(dist_ff));
      both65 = {1'b0, ta_ff} + {1'b0, td_ff};
      both   = both65[64] ? '1 : both65[63:0];
      tf65   = {1'b0, tmp_ff} + {1'b0, (both >> 1)};
      tf_s   = tf65[64] ? '1 : tf65[63:0];
      ce     = (tf_ff >= td_ff) ? (tf_ff - td_ff) : 64'd0;
      down   = end_ff < start_ff;
      sdist  = down ? 33'({start_ff[31], start_ff} - {end_ff[31], end_ff})
                    : 33'({end_ff[31], end_ff} - {start_ff[31], start_ff});
      r_v    = rnd(tmp_ff);
      if (dm_ff) begin
         n_v = (r_v >= 64'(sdist)) ? 64'd0 : 64'(sdist) - r_v;
      end else begin
         n_v = umin(r_v, 64'(sdist));
      end
      newpos = down ? (34'(start_ff) - 34'(n_v[32:0]))
                    : (34'(start_ff) + 34'(n_v[32:0]));

      if (op_state) begin
         if (!wait_ff) begin
            wait_in = 1'b1;
         end else if (md_rsp.done) begin
            wait_in = 1'b0;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               qi_in   = in_item.cur_pos;
               qf_in   = qf_clamp;
               dist_in = dist_new;
               vel_in  = in_item.velocity_rpm;
               acc_in  = in_item.accel_rpm;
               dec_in  = in_item.decel_rpm;
               idx_in  = in_item.sample_index;
               state_in = (in_item.func == FUNC_SAMPLE) ? S_T : S_V;
            end
         end
         S_V:    if (op_done) begin v_in = q; state_in = S_VMAX; end
         S_VMAX: if (op_done) begin v_in = umin(v_ff, q); state_in = S_A; end
         S_A:    if (op_done) begin a_in = q; state_in = S_D; end
         S_D:    if (op_done) begin d_in = q; state_in = S_AMAX; end
         S_AMAX: if (op_done) begin amax_in = q; state_in = S_LIM; end
         S_LIM:  if (op_done) begin lim_in = q; state_in = S_CLAMP; end
         S_CLAMP: begin
            start_in  = qi_ff;
            last_in   = qi_ff;
            raised_in = 1'b0;
            pos_in    = '0;
            if ((dist_ff == 33'd0) || (v_ff == 64'd0)) begin
               // degenerate move: hold the start
               end_in = qi_ff;
               v_in = '0; a_in = '0; d_in = '0;
               ta_in = '0; td_in = '0; tf_in = '0;
               cnt_in = '0;
               state_in = S_FIN;
            end else begin
               end_in = qf_ff;
               a_in = a_c;
               d_in = d_c;
               state_in = S_X1;
            end
         end
         S_X1: if (op_done) begin x1_in = q; state_in = S_X2; end
         S_X2: if (op_done) begin tmp_in = q; state_in = S_FIT; end
         S_FIT: begin
            // blends overrun the distance: lower velocity, raise rates
            if (sum65 > 65'(dist_ff)) begin
               raised_in = 1'b1;
               v_in = vn;
               a_in = umax(a_ff, vn);
               d_in = umax(d_ff, vn);
            end
            state_in = S_TA;
         end
         S_TA: if (op_done) begin ta_in = q; state_in = S_TD; end
         S_TD: if (op_done) begin td_in = q; state_in = S_T1; end
         S_T1: if (op_done) begin tmp_in = q; state_in = S_TF; end
         S_TF: begin
            tf_in = umax(tf_s, both);
            state_in = S_CNT;
         end
         S_CNT: begin
            if (op_done) begin
               cnt_in = (cnt_r > 64'h7FFF_FFFF) ? '1 : cnt_r[30:0];
               state_in = S_FIN;
            end
         end
         S_T: if (op_done) begin t_in = q; state_in = S_SEL; end
         S_SEL: begin
            cnt_in = '0;
            if (t_ff < ta_ff) begin
               w_in = t_ff; dm_in = 1'b0; state_in = S_P;
            end else if (t_ff < ce) begin
               w_in = t_ff - (ta_ff >> 1); dm_in = 1'b0; state_in = S_CRU;
            end else if (t_ff <= tf_ff) begin
               w_in = tf_ff - t_ff; dm_in = 1'b1; state_in = S_P;
            end else begin
               // past the end: hold the last position
               pos_in = last_ff; state_in = S_FIN;
            end
         end
         S_P:   if (op_done) begin tmp_in = q; state_in = S_Q; end
         S_Q:   if (op_done) begin tmp_in = q; state_in = S_POS; end
         S_CRU: if (op_done) begin tmp_in = q; state_in = S_POS; end
         S_POS: begin
            last_in  = newpos[31:0];
            pos_in   = newpos[31:0];
            state_in = S_FIN;
         end
         S_FIN: if (out_take) begin state_in = S_IDLE; end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         wait_ff  <= 1'b0;
         start_ff <= '0; end_ff <= '0; last_ff <= '0;
         v_ff <= '0; a_ff <= '0; d_ff <= '0;
         ta_ff <= '0; td_ff <= '0; tf_ff <= '0;
         raised_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         wait_ff  <= wait_in;
         start_ff <= start_in; end_ff <= end_in; last_ff <= last_in;
         v_ff <= v_in; a_ff <= a_in; d_ff <= d_in;
         ta_ff <= ta_in; td_ff <= td_in; tf_ff <= tf_in;
         raised_ff <= raised_in;
      end
      qi_ff <= qi_in; qf_ff <= qf_in; dist_ff <= dist_in;
      vel_ff <= vel_in; acc_ff <= acc_in; dec_ff <= dec_in; idx_ff <= idx_in;
      amax_ff <= amax_in; lim_ff <= lim_in; x1_ff <= x1_in;
      tmp_ff <= tmp_in; t_ff <= t_in; w_ff <= w_in; dm_ff <= dm_in;
      pos_ff <= pos_in; cnt_ff <= cnt_in;
   end

   assign busy                  = (state_ff != S_IDLE);
   assign out_valid             = (state_ff == S_FIN);
   assign out_item.sample_count = cnt_ff;
   assign out_item.position     = pos_ff;
   assign out_item.accel_raised = raised_ff;

endmodule

>>> hdl/trapezoid_position_profile.sv
// ----------------------------------------------------------------------------
// trapezoid_position_profile
// Trapezoidal position profile: plans a move and returns profile samples.
// ----------------------------------------------------------------------------
//  channel | ports          | direction | content
//  request | req_*          | in        | plan or sample item
//  result  | rsp_*          | out       | sample count, position, raised flag
//  config  | csr_* (APB)    | in/out    | six limit and scale registers
//
// Every arithmetic step runs on the shared multiply-divide unit (start,
// 4 partial products, a range check, 64 quotient bits, done); a step that
// saturates ends after the range check. A plan item takes 12 steps; a
// zero-distance or zero-velocity plan stops after 6 steps. A sample item
// works out its time, then its position in a blend or in cruise; past the
// end it holds the last position.
// Reset is synchronous and clears control and profile state, no sweep needed.
// req_stall is high while an item is in work; one finished item may wait in
// the output register under rsp_stall while the next item is accepted.
// ----------------------------------------------------------------------------
module trapezoid_position_profile #(
   parameter int SAMPLE_RATE_HZ = tpp_pkg::SampleRateHzDefault,
   parameter int FRAC_BITS      = tpp_pkg::FracBitsDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  tpp_pkg::req_item_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output tpp_pkg::rsp_item_type rsp_data,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [4:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready
);
   import tpp_pkg::*;

   cfg_type      cfg_ff, cfg_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_data_ff, rsp_data_in;
   logic         seq_busy, seq_out_valid, out_take, req_accept, cfg_write;
   rsp_item_type seq_out_item;
   md_req_type   md_req;
   md_rsp_type   md_rsp;

   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Register write
   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_write) begin
         case (reg_index_type'(csr_paddr[4:2]))
            REG_TICKS_PER_TURN:   cfg_in.ticks_per_turn   = csr_pwdata[20:0];
            REG_MAX_ACCEL_RPM:    cfg_in.max_accel_rpm    = csr_pwdata[19:0];
            REG_MAX_VELOCITY_RPM: cfg_in.max_velocity_rpm = csr_pwdata[19:0];
            REG_POS_UPPER:        cfg_in.pos_upper        = csr_pwdata;
            REG_POS_LOWER:        cfg_in.pos_lower        = csr_pwdata;
            REG_ACCEL_DIST_GAIN:  cfg_in.accel_dist_gain  = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   // Register read
   always_comb begin
      case (reg_index_type'(csr_paddr[4:2]))
         REG_TICKS_PER_TURN:   csr_prdata = 32'(cfg_ff.ticks_per_turn);
         REG_MAX_ACCEL_RPM:    csr_prdata = 32'(cfg_ff.max_accel_rpm);
         REG_MAX_VELOCITY_RPM: csr_prdata = 32'(cfg_ff.max_velocity_rpm);
         REG_POS_UPPER:        csr_prdata = cfg_ff.pos_upper;
         REG_POS_LOWER:        csr_prdata = cfg_ff.pos_lower;
         REG_ACCEL_DIST_GAIN:  csr_prdata = 32'(cfg_ff.accel_dist_gain);
         default:              csr_prdata = '0;
      endcase
   end

   assign req_stall  = seq_busy;
   assign req_accept = req_valid && !req_stall;

   // Move a finished item into the output register when it has room
   assign out_take = seq_out_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (out_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = seq_out_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ticks_per_turn   <= 21'd4096;
         cfg_ff.max_accel_rpm    <= 20'd1000;
         cfg_ff.max_velocity_rpm <= 20'd1000;
         cfg_ff.pos_upper        <= 32'sh7FFF_FFFF;
         cfg_ff.pos_lower        <= 32'sh8000_0000;
         cfg_ff.accel_dist_gain  <= 8'd10;
         rsp_valid_ff            <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   tpp_seq #(
      .SAMPLE_RATE_HZ(SAMPLE_RATE_HZ),
      .FRAC_BITS     (FRAC_BITS)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .in_valid (req_accept),
      .in_item  (req_data),
      .busy     (seq_busy),
      .out_valid(seq_out_valid),
      .out_take (out_take),
      .out_item (seq_out_item),
      .md_req   (md_req),
      .md_rsp   (md_rsp)
   );

   tpp_muldiv u_muldiv (
      .clock (clock),
      .reset (reset),
      .md_req(md_req),
      .md_rsp(md_rsp)
   );

   // An accepted item keeps the sequencer busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> req_stall)
      else $error("request not held off after accept");

   // A result carries either a sample count or a position, never both
   a_rsp_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.sample_count == 31'd0 || rsp_data.position == 32'sd0))
      else $error("result holds both count and position");

   // The output register loads only from a finished sequencer item
   a_load_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(rsp_valid)) |-> $past(seq_out_valid))
      else $error("result appeared without a finished item");

endmodule

>>> tb/trapezoid_position_profile_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trapezoid_position_profile_tb
// Drives plan and sample items with random idling on both channels, predicts
// every result with a fixed-point profile model and checks each field.
// ----------------------------------------------------------------------------

// Expected results and the profile state they are worked out from
class profile_scoreboard;
   typedef bit [127:0] wide_type;

   bit [63:0] ticks_turn, amax_rpm, vmax_rpm, lfactor;
   longint    pos_hi, pos_lo;
   longint    p_start, p_end, p_last;
   bit [63:0] acc, dec, vel, t_acc, t_dec, t_half, t_total;
   bit        raised;
   tpp_pkg::rsp_item_type pending[$];
   int        errors;

   function new();
      ticks_turn = 4096; amax_rpm = 1000; vmax_rpm = 1000; lfactor = 10;
      pos_hi = 2147483647; pos_lo = -2147483647 - 1;
      p_start = 0; p_end = 0; p_last = 0;
      acc = 0; dec = 0; vel = 0; t_acc = 0; t_dec = 0; t_half = 0; t_total = 0;
      raised = 0; errors = 0;
   endfunction

   function void set_reg(tpp_pkg::reg_index_type idx, bit [31:0] value);
      case (idx)
         tpp_pkg::REG_TICKS_PER_TURN:   ticks_turn = value[20:0];
         tpp_pkg::REG_MAX_ACCEL_RPM:    amax_rpm = value[19:0];
         tpp_pkg::REG_MAX_VELOCITY_RPM: vmax_rpm = value[19:0];
         tpp_pkg::REG_POS_UPPER:        pos_hi = longint'($signed(value));
         tpp_pkg::REG_POS_LOWER:        pos_lo = longint'($signed(value));
         tpp_pkg::REG_ACCEL_DIST_GAIN:  lfactor = value[7:0];
         default: ;
      endcase
   endfunction

   // floor(a*b/c) saturated, zero divisor saturates
   function bit [63:0] scale(bit [63:0] a, bit [63:0] b, bit [63:0] c);
      wide_type p;
      p = wide_type'(a) * wide_type'(b);
      if (c == 0 || (p >> 64) >= c) return '1;
      return 64'(p / c);
   endfunction

   function bit [63:0] sat_add(bit [63:0] a, bit [63:0] b);
      bit [64:0] s;
      s = a + b;
      return s[64] ? '1 : s[63:0];
   endfunction

   function bit [63:0] round_q(bit [63:0] x);
      return ((x >> 31) + 1) >> 1;
   endfunction

   function bit [63:0] to_rate(bit [63:0] rpm);
      return (rpm & 64'hFFFFF) * ticks_turn / 60;
   endfunction

   function bit [30:0] plan_move(tpp_pkg::req_item_type it);
      longint qi, qf;
      bit [63:0] v, a, d, travel, lim, both, tf, n;
      qi = longint'(it.cur_pos);
      qf = longint'(it.goal_pos);
      if (qf > pos_hi) qf = pos_hi;
      else if (qf < pos_lo) qf = pos_lo;
      v = to_rate(it.velocity_rpm);
      a = to_rate(it.accel_rpm);
      d = to_rate(it.decel_rpm);
      travel = (qf >= qi) ? qf - qi : qi - qf;
      if (v > to_rate(vmax_rpm)) v = to_rate(vmax_rpm);
      lim = lfactor * travel;
      if (a > lim) a = lim;
      if (a > to_rate(amax_rpm)) a = to_rate(amax_rpm);
      if (d > lim) d = lim;
      if (d > to_rate(amax_rpm)) d = to_rate(amax_rpm);
      p_start = qi; p_last = qi; raised = 0;
      if (travel == 0 || v == 0) begin
         p_end = qi;
         acc = 0; dec = 0; vel = 0; t_acc = 0; t_dec = 0; t_total = 0; t_half = 0;
         return 0;
      end
      p_end = qf;
      if (sat_add(scale(v, v, 2 * a), scale(v, v, 2 * d)) > travel) begin
         raised = 1;
         if (v > travel) v = travel;
         if (a < v) a = v;
         if (d < v) d = v;
      end
      acc = a; dec = d; vel = v;
      t_acc = scale(v, 64'h1_0000_0000, a);
      t_dec = scale(v, 64'h1_0000_0000, d);
      t_half = t_acc >> 1;
      both = sat_add(t_acc, t_dec);
      tf = sat_add(scale(travel, 64'h1_0000_0000, v), both >> 1);
      if (tf < both) tf = both;
      t_total = tf;
      n = round_q(scale(tf, 1000, 1));
      return (n > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : n[30:0];
   endfunction

   function bit [31:0] sample_at(bit [23:0] idx);
      bit [63:0] t, travel, n, cruise_end, w, rem;
      bit down;
      t = scale(idx, 64'h1_0000_0000, 1000);
      down = p_end < p_start;
      travel = down ? p_start - p_end : p_end - p_start;
      cruise_end = (t_total >= t_dec) ? t_total - t_dec : 0;
      if (t < t_acc) n = round_q(scale(acc, scale(t, t, 64'h1_0000_0000), 2));
      else if (t < cruise_end) n = round_q(scale(vel, t - t_half, 1));
      else if (t <= t_total) begin
         w = t_total - t;
         rem = round_q(scale(dec, scale(w, w, 64'h1_0000_0000), 2));
         n = (rem >= travel) ? 0 : travel - rem;
      end else return p_last[31:0];
      if (n > travel) n = travel;
      p_last = down ? p_start - longint'(n) : p_start + longint'(n);
      return p_last[31:0];
   endfunction

   // Note an accepted item and queue its result
   function void note_item(tpp_pkg::req_item_type it);
      tpp_pkg::rsp_item_type r;
      r = '0;
      if (it.func == tpp_pkg::FUNC_PLAN) r.sample_count = plan_move(it);
      else r.position = sample_at(it.sample_index);
      r.accel_raised = raised;
      pending.push_back(r);
   endfunction

   task report(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
   endtask

   task check_result(tpp_pkg::rsp_item_type got);
      tpp_pkg::rsp_item_type want;
      if (pending.size() == 0) begin
         report("unexpected result count", 1, 0);
         return;
      end
      want = pending.pop_front();
      if (got.sample_count !== want.sample_count)
         report("sample_count", got.sample_count, want.sample_count);
      if (got.position !== want.position)
         report("position", got.position, want.position);
      if (got.accel_raised !== want.accel_raised)
         report("accel_raised", got.accel_raised, want.accel_raised);
   endtask
endclass

module trapezoid_position_profile_tb;
   import tpp_pkg::*;

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_stall, rsp_valid, rsp_stall = 0;
   req_item_type req_data = '0;
   rsp_item_type rsp_data;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0, csr_pready;
   logic [4:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0, csr_prdata;
   profile_scoreboard board;
   longint cycles = 0;

   trapezoid_position_profile i_dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // Check results and note accepted items at the rising edge
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 64'd60_000_000) begin
         $display("*** FAILED ***");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_data);
      if (!reset && req_valid && !req_stall) board.note_item(req_data);
   end

   // Receiver stall pattern: random phases of busy, quiet and heavy stalling
   int stall_mode = 0;
   always @(negedge clock) begin
      if ($urandom_range(0, 299) == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_stall <= 0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         default: rsp_stall <= ($urandom_range(0, 9) != 0);
      endcase
   end

   task automatic csr_write(reg_index_type idx, logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1; csr_pwrite <= 1; csr_penable <= 0;
      csr_paddr <= 5'(idx) << 2; csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1;
      @(negedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      board.set_reg(idx, value);
   endtask

   // Present one item and hold it until accepted
   task automatic send(req_item_type it);
      @(negedge clock);
      req_valid <= 1; req_data <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      req_valid <= 0;
   endtask

   task automatic drain();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (1200) @(posedge clock);
   endtask

   function automatic req_item_type plan_item(int pos_range, int rate_max);
      req_item_type it;
      it = '0;
      it.func = FUNC_PLAN;
      if (pos_range == 0) begin
         it.goal_pos = $urandom; it.cur_pos = $urandom;
      end else begin
         it.cur_pos = $signed($urandom_range(0, 2 * pos_range)) - pos_range;
         it.goal_pos = $signed($urandom_range(0, 2 * pos_range)) - pos_range;
      end
      it.velocity_rpm = $urandom_range(0, rate_max);
      it.accel_rpm = $urandom_range(0, rate_max);
      it.decel_rpm = $urandom_range(0, rate_max);
      it.sample_index = $urandom;
      return it;
   endfunction

   function automatic req_item_type sample_item(int hi);
      req_item_type it;
      it = '0;
      it.func = FUNC_SAMPLE;
      it.sample_index = $urandom_range(0, hi);
      it.goal_pos = $urandom; it.cur_pos = $urandom;
      it.velocity_rpm = $urandom; it.accel_rpm = $urandom; it.decel_rpm = $urandom;
      return it;
   endfunction

   // Random phase: plans followed by sample sweeps, bursts and gaps
   task automatic random_phase(int count, int pos_range, int rate_max);
      req_item_type it;
      int burst, span;
      span = 2000;
      burst = 0;
      for (int k = 0; k < count; k++) begin
         if (burst == 0) begin
            repeat ($urandom_range(0, 40)) @(negedge clock);
            burst = $urandom_range(1, 12);
         end
         burst--;
         if ($urandom_range(0, 7) == 0) begin
            it = plan_item($urandom_range(0, 3) == 0 ? 0 : pos_range, rate_max);
         end else if ($urandom_range(0, 15) == 0) begin
            it = sample_item(24'hFFFFFF);
         end else begin
            it = sample_item(span);
         end
         send(it);
         if (it.func == FUNC_PLAN && board.pending.size() != 0) begin
            if (board.pending[$].sample_count > 31'(24'hFFFFFF)) span = 24'hFFFFFF;
            else span = int'(board.pending[$].sample_count) + 20;
            if (span > 24'hFFFFFF) span = 24'hFFFFFF;
         end
      end
   endtask

   initial begin
      req_item_type it;
      board = new();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: samples before any plan, extremes and special cases
      send(sample_item(0));
      send(sample_item(24'hFFFFFF));
      it = plan_item(1000, 1000);
      it.goal_pos = 1000; it.cur_pos = 1000; send(it);
      send(sample_item(100));
      it = plan_item(1000, 1000);
      it.goal_pos = 2000; it.cur_pos = 0; it.velocity_rpm = 0; send(it);
      send(sample_item(10));
      it = plan_item(0, 1000);
      it.goal_pos = 32'h7FFFFFFF; it.cur_pos = 32'h80000000;
      it.velocity_rpm = 20'hFFFFF; it.accel_rpm = 20'hFFFFF; it.decel_rpm = 20'hFFFFF;
      send(it);
      send(sample_item(0)); send(sample_item(1)); send(sample_item(24'hFFFFFF));
      it.goal_pos = 32'h80000000; it.cur_pos = 32'h7FFFFFFF;
      it.accel_rpm = 0; it.decel_rpm = 0; send(it);
      send(sample_item(5)); send(sample_item(24'hFFFFFF));
      it = plan_item(0, 0);
      it.goal_pos = 500; it.cur_pos = -500;
      it.velocity_rpm = 600; it.accel_rpm = 900; it.decel_rpm = 300; send(it);
      for (int k = 0; k < 8; k++) send(sample_item(4000));
      drain();

      // Default limits
      random_phase(400, 200000, 2000);
      drain();

      // Unit ticks per turn, widest rate limits, inverted position window, zero distance gain
      csr_write(REG_TICKS_PER_TURN, 1);
      csr_write(REG_MAX_ACCEL_RPM, 20'hFFFFF);
      csr_write(REG_MAX_VELOCITY_RPM, 20'hFFFFF);
      csr_write(REG_POS_UPPER, -1000);
      csr_write(REG_POS_LOWER, 1000);
      csr_write(REG_ACCEL_DIST_GAIN, 0);
      random_phase(300, 5000, 20'hFFFFF);
      drain();

      // Zero ticks per turn: every plan is a zero-velocity move
      csr_write(REG_TICKS_PER_TURN, 0);
      csr_write(REG_ACCEL_DIST_GAIN, 8'hFF);
      csr_write(REG_POS_UPPER, 32'h7FFFFFFF);
      csr_write(REG_POS_LOWER, 32'h80000000);
      random_phase(100, 100000, 20'hFFFFF);
      drain();

      // Large scale and largest item rates
      csr_write(REG_TICKS_PER_TURN, 21'h100000);
      csr_write(REG_MAX_ACCEL_RPM, 0);
      random_phase(300, 0, 20'hFFFFF);
      drain();
      csr_write(REG_MAX_ACCEL_RPM, 50000);
      csr_write(REG_MAX_VELOCITY_RPM, 0);
      random_phase(100, 100000, 20'hFFFFF);
      drain();

      // Moderate window with random limits
      csr_write(REG_TICKS_PER_TURN, $urandom_range(1, 20000));
      csr_write(REG_MAX_VELOCITY_RPM, $urandom_range(100, 5000));
      csr_write(REG_MAX_ACCEL_RPM, $urandom_range(100, 50000));
      csr_write(REG_POS_UPPER, 50000);
      csr_write(REG_POS_LOWER, -50000);
      csr_write(REG_ACCEL_DIST_GAIN, 1);
      random_phase(800, 80000, 6000);
      drain();

      if (board.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule

>>> sim.f
hdl/tpp_pkg.sv
hdl/tpp_muldiv.sv
hdl/tpp_seq.sv
hdl/trapezoid_position_profile.sv
tb/trapezoid_position_profile_tb.sv
